/* design/jpcm_pkg.sv */
package jpcm_pkg;

	localparam int MAX_PARTICLES = 64;
	localparam int ADDR_W        = $clog2(MAX_PARTICLES);
	localparam int CNT_W         = $clog2(MAX_PARTICLES + 1);

	localparam int COORD_W = 14;
	localparam int ID_W    = 24;
	localparam int TIDX_W  = 4;
	localparam int CONE_W  = 29;
	localparam int DIFF_W  = COORD_W + 1;
	localparam int SQ_W    = 2 * COORD_W + 1;
	localparam int SUM_W   = SQ_W + 1;

	localparam int HIT_W       = 7;
	localparam logic [HIT_W-1:0] HIT_MAX = 7'd127;
	localparam int EJB_W       = 8;
	localparam int TALLY_W     = 32;
	localparam int NUM_TALLIES = 10;

	localparam logic [CONE_W-1:0] CONE_RESET = 29'd671089;

	localparam logic signed [ID_W-1:0] ID_B         = 24'sd5;
	localparam logic signed [ID_W-1:0] ID_LIGHT_MAX = 24'sd4;
	localparam logic signed [ID_W-1:0] ID_ELECTRON  = 24'sd11;
	localparam logic signed [ID_W-1:0] ID_MUON      = 24'sd13;

	// tally slots
	localparam int TALLY_ONE_B    = 0;
	localparam int TALLY_TWO_B    = 1;
	localparam int TALLY_ONE_LT   = 2;
	localparam int TALLY_MULTI_B  = 3;
	localparam int TALLY_ELEC_ONL = 4;
	localparam int TALLY_MUON_ONL = 5;
	localparam int TALLY_EV0      = 6;
	localparam int NUM_EV_TALLIES = 4;

	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_MATCH = 2'd1,
		CMD_CLOSE = 2'd2,
		CMD_READ  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_JET   = 2'd0,
		KIND_CLOSE = 2'd1,
		KIND_TALLY = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		CLS_NONE  = 3'd0,
		CLS_B     = 3'd1,
		CLS_LIGHT = 3'd2,
		CLS_ELEC  = 3'd3,
		CLS_MUON  = 3'd4
	} cls_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_SCAN = 2'd1,
		ST_DONE = 2'd2
	} state_t;

	typedef struct packed {
		cls_t                      cls;
		logic signed [COORD_W-1:0] phi;
		logic signed [COORD_W-1:0] eta;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic valid;
		logic in_cone;
		cls_t cls;
	} hit_t;

	function automatic cls_t classify(input logic signed [ID_W-1:0] id);
		cls_t c;
		c = CLS_NONE;
		if (id == ID_B || id == -ID_B) begin
			c = CLS_B;
		end else if (id >= -ID_LIGHT_MAX && id <= ID_LIGHT_MAX) begin
			c = CLS_LIGHT;
		end else if (id == ID_ELECTRON || id == -ID_ELECTRON) begin
			c = CLS_ELEC;
		end else if (id == ID_MUON || id == -ID_MUON) begin
			c = CLS_MUON;
		end
		return c;
	endfunction

endpackage

/* design/jpcm_ram.sv */
module jpcm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* design/jpcm_dist.sv */
module jpcm_dist (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                valid,
	input  logic signed [jpcm_pkg::COORD_W-1:0] jet_eta,
	input  logic signed [jpcm_pkg::COORD_W-1:0] jet_phi,
	input  jpcm_pkg::entry_t                    part,
	input  logic [jpcm_pkg::CONE_W-1:0]         cone,
	output jpcm_pkg::hit_t                      hit
);

	logic signed [jpcm_pkg::DIFF_W-1:0]   de, dp;
	logic signed [2*jpcm_pkg::DIFF_W-1:0] de2, dp2;
	logic [jpcm_pkg::SQ_W-1:0]            de2_s1, dp2_s1;
	jpcm_pkg::cls_t                       cls_s1;
	logic                                 valid_s1;
	logic [jpcm_pkg::SUM_W-1:0]           sum;

	assign de  = {jet_eta[jpcm_pkg::COORD_W-1], jet_eta}
		- {part.eta[jpcm_pkg::COORD_W-1], part.eta};
	assign dp  = {jet_phi[jpcm_pkg::COORD_W-1], jet_phi}
		- {part.phi[jpcm_pkg::COORD_W-1], part.phi};
	assign de2 = de * de;
	assign dp2 = dp * dp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		de2_s1 <= de2[jpcm_pkg::SQ_W-1:0];
		dp2_s1 <= dp2[jpcm_pkg::SQ_W-1:0];
		cls_s1 <= part.cls;
	end

	assign sum = {1'b0, de2_s1} + {1'b0, dp2_s1};

	always_comb begin
		hit.valid   = valid_s1;
		hit.in_cone = sum <= {{(jpcm_pkg::SUM_W - jpcm_pkg::CONE_W){1'b0}}, cone};
		hit.cls     = cls_s1;
	end

endmodule

/* design/jet_particle_cone_matcher.sv */
// Delta-R cone matcher. Load particles (tuser 0) into a 64-entry store; loads
// beyond 64 are dropped. A jet (tuser 1) is compared with every stored particle
// and a particle counts when deta^2 + dphi^2 <= cone_radius_sq (inclusive,
// phi does not wrap). Closing an event (tuser 2) reports jets with a b and
// empties the store; tuser 3 reads one of ten saturating tallies. A jet holds
// the input while one shared square-and-compare unit checks one stored
// particle per cycle behind the registered read of the particle store; the
// counts are registered once the last compare drains, and the jet then waits
// until the output register is free. Close and tally read are held off while
// the output register is full; loads and jets are not.
module jet_particle_cone_matcher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [28:0] cfg_wdata,    // cone_radius_sq
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,      // eta, phi, particle_id, tally_index
	input  logic [1:0]  s_tuser,      // cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,      // b_count, light_count, electron_count,
	                                  // muon_count, jet_has_b, jets_with_b,
	                                  // tally_value, zero pad
	output logic [1:0]  m_tuser       // kind
);

	localparam int HW = jpcm_pkg::HIT_W;

	jpcm_pkg::state_t state_q, state_d;
	jpcm_pkg::cmd_t   cmd;

	logic [jpcm_pkg::CONE_W-1:0]         cone_q;
	logic [jpcm_pkg::CNT_W-1:0]          cnt_q, idx_q;
	logic [jpcm_pkg::EJB_W-1:0]          ejb_q;
	logic [jpcm_pkg::TALLY_W-1:0]        tally_q [jpcm_pkg::NUM_TALLIES];
	logic [jpcm_pkg::NUM_TALLIES-1:0]    tinc;
	logic signed [jpcm_pkg::COORD_W-1:0] jet_eta_q, jet_phi_q;
	logic [HW-1:0]                       nb_q, nl_q, ne_q, nm_q;
	logic                                rd_v_s1;
	logic                                out_valid_q;
	logic [71:0]                         out_data_q;
	logic [1:0]                          out_user_q;

	logic                                accept, out_free, issue, jet_out, scan_end;
	logic                                ram_we;
	jpcm_pkg::entry_t                    wr_entry, rd_entry;
	jpcm_pkg::hit_t                      hit;
	logic signed [jpcm_pkg::COORD_W-1:0] in_eta, in_phi;
	logic signed [jpcm_pkg::ID_W-1:0]    in_id;
	logic [jpcm_pkg::TIDX_W-1:0]         in_tidx;
	logic [jpcm_pkg::TALLY_W-1:0]        tally_rd;

	assign cmd     = jpcm_pkg::cmd_t'(s_tuser);
	assign in_eta  = s_tdata[13:0];
	assign in_phi  = s_tdata[27:14];
	assign in_id   = s_tdata[51:28];
	assign in_tidx = s_tdata[55:52];

	assign out_free = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign scan_end = (idx_q == cnt_q) && !rd_v_s1 && !hit.valid;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			jpcm_pkg::ST_IDLE: begin
				if (accept && cmd == jpcm_pkg::CMD_MATCH) begin
					state_d = jpcm_pkg::ST_SCAN;
				end
			end
			jpcm_pkg::ST_SCAN: begin
				if (scan_end) begin
					state_d = jpcm_pkg::ST_DONE;
				end
			end
			jpcm_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = jpcm_pkg::ST_IDLE;
				end
			end
			default: state_d = jpcm_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready = 1'b0;
		issue    = 1'b0;
		jet_out  = 1'b0;
		case (state_q)
			jpcm_pkg::ST_IDLE: begin
				s_tready = cmd == jpcm_pkg::CMD_LOAD || cmd == jpcm_pkg::CMD_MATCH
					|| out_free;
			end
			jpcm_pkg::ST_SCAN: begin
				issue = idx_q < cnt_q;
			end
			jpcm_pkg::ST_DONE: begin
				jet_out = out_free;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	assign ram_we       = accept && cmd == jpcm_pkg::CMD_LOAD
		&& cnt_q < jpcm_pkg::CNT_W'(jpcm_pkg::MAX_PARTICLES);
	assign wr_entry.cls = jpcm_pkg::classify(in_id);
	assign wr_entry.phi = in_phi;
	assign wr_entry.eta = in_eta;

	jpcm_ram #(
		.WIDTH (jpcm_pkg::ENTRY_W),
		.DEPTH (jpcm_pkg::MAX_PARTICLES)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cnt_q[jpcm_pkg::ADDR_W-1:0]),
		.wdata (wr_entry),
		.raddr (idx_q[jpcm_pkg::ADDR_W-1:0]),
		.rdata (rd_entry)
	);

	jpcm_dist u_dist (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid   (rd_v_s1),
		.jet_eta (jet_eta_q),
		.jet_phi (jet_phi_q),
		.part    (rd_entry),
		.cone    (cone_q),
		.hit     (hit)
	);

	assign tally_rd = (in_tidx < jpcm_pkg::TIDX_W'(jpcm_pkg::NUM_TALLIES))
		? tally_q[in_tidx] : '0;

	always_comb begin
		tinc = '0;
		if (jet_out) begin
			tinc[jpcm_pkg::TALLY_ONE_B]    = nb_q == HW'(1);
			tinc[jpcm_pkg::TALLY_TWO_B]    = nb_q == HW'(2);
			tinc[jpcm_pkg::TALLY_ONE_LT]   = nl_q == HW'(1);
			tinc[jpcm_pkg::TALLY_MULTI_B]  = nb_q > HW'(1);
			tinc[jpcm_pkg::TALLY_ELEC_ONL] = ne_q != '0 && nb_q == '0 && nl_q == '0;
			tinc[jpcm_pkg::TALLY_MUON_ONL] = nm_q != '0 && nb_q == '0 && nl_q == '0;
		end
		for (int k = 0; k < jpcm_pkg::NUM_EV_TALLIES; k++) begin
			if (accept && cmd == jpcm_pkg::CMD_CLOSE
				&& ejb_q == jpcm_pkg::EJB_W'(k)) begin
				tinc[jpcm_pkg::TALLY_EV0 + k] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= jpcm_pkg::ST_IDLE;
			cone_q      <= jpcm_pkg::CONE_RESET;
			cnt_q       <= '0;
			idx_q       <= '0;
			ejb_q       <= '0;
			rd_v_s1     <= 1'b0;
			out_valid_q <= 1'b0;
			nb_q        <= '0;
			nl_q        <= '0;
			ne_q        <= '0;
			nm_q        <= '0;
			for (int k = 0; k < jpcm_pkg::NUM_TALLIES; k++) begin
				tally_q[k] <= '0;
			end
		end else begin
			state_q <= state_d;
			rd_v_s1 <= issue;
			if (cfg_we) begin
				cone_q <= cfg_wdata;
			end
			for (int k = 0; k < jpcm_pkg::NUM_TALLIES; k++) begin
				if (tinc[k] && tally_q[k] != '1) begin
					tally_q[k] <= tally_q[k] + 1'b1;
				end
			end
			if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (ram_we) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (accept && cmd == jpcm_pkg::CMD_MATCH) begin
				idx_q <= '0;
				nb_q  <= '0;
				nl_q  <= '0;
				ne_q  <= '0;
				nm_q  <= '0;
			end
			if (accept && cmd == jpcm_pkg::CMD_CLOSE) begin
				cnt_q <= '0;
				ejb_q <= '0;
			end
			if (accept && (cmd == jpcm_pkg::CMD_CLOSE || cmd == jpcm_pkg::CMD_READ)) begin
				out_valid_q <= 1'b1;
			end
			if (issue) begin
				idx_q <= idx_q + 1'b1;
			end
			// count a particle inside the cone, saturating
			if (hit.valid && hit.in_cone) begin
				case (hit.cls)
					jpcm_pkg::CLS_B:     if (nb_q != jpcm_pkg::HIT_MAX) nb_q <= nb_q + 1'b1;
					jpcm_pkg::CLS_LIGHT: if (nl_q != jpcm_pkg::HIT_MAX) nl_q <= nl_q + 1'b1;
					jpcm_pkg::CLS_ELEC:  if (ne_q != jpcm_pkg::HIT_MAX) ne_q <= ne_q + 1'b1;
					jpcm_pkg::CLS_MUON:  if (nm_q != jpcm_pkg::HIT_MAX) nm_q <= nm_q + 1'b1;
					default: ;
				endcase
			end
			if (jet_out) begin
				out_valid_q <= 1'b1;
				if (nb_q != '0 && ejb_q != '1) begin
					ejb_q <= ejb_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && cmd == jpcm_pkg::CMD_MATCH) begin
			jet_eta_q <= in_eta;
			jet_phi_q <= in_phi;
		end
		if (accept && cmd == jpcm_pkg::CMD_CLOSE) begin
			out_user_q <= jpcm_pkg::KIND_CLOSE;
			out_data_q <= {3'b0, 32'b0, ejb_q, 1'b0, 28'b0};
		end
		if (accept && cmd == jpcm_pkg::CMD_READ) begin
			out_user_q <= jpcm_pkg::KIND_TALLY;
			out_data_q <= {3'b0, tally_rd, 8'b0, 1'b0, 28'b0};
		end
		if (jet_out) begin
			out_user_q <= jpcm_pkg::KIND_JET;
			out_data_q <= {3'b0, 32'b0, 8'b0, nb_q != '0, nm_q, ne_q, nl_q, nb_q};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= jpcm_pkg::CNT_W'(jpcm_pkg::MAX_PARTICLES))
		else $error("particle count beyond store depth");

	a_scan_idx: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == jpcm_pkg::ST_SCAN |-> idx_q <= cnt_q)
		else $error("scan index ran past particle count");

	a_done_drained: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == jpcm_pkg::ST_DONE |-> !rd_v_s1 && !hit.valid)
		else $error("jet finished with compares in flight");

	a_jet_result: assert property (@(posedge clk) disable iff (!arst_n)
		jet_out |=> m_tvalid && m_tuser == jpcm_pkg::KIND_JET
			&& state_q == jpcm_pkg::ST_IDLE)
		else $error("jet result not presented");
`endif

endmodule

/* dv/tb_jet_particle_cone_matcher.sv */
module tb_jet_particle_cone_matcher;
	import jpcm_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 80;

	typedef struct {
		cmd_t                      cmd;
		logic signed [COORD_W-1:0] eta;
		logic signed [COORD_W-1:0] phi;
		logic signed [ID_W-1:0]    pid;
		logic [TIDX_W-1:0]         tidx;
		int                        gap;
		bit                        drain;
	} stim_t;

	typedef struct {
		kind_t              kind;
		logic [HIT_W-1:0]   nb;
		logic [HIT_W-1:0]   nl;
		logic [HIT_W-1:0]   ne;
		logic [HIT_W-1:0]   nm;
		logic               has_b;
		logic [EJB_W-1:0]   jwb;
		logic [TALLY_W-1:0] tally;
	} result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [28:0] cfg_wdata = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [55:0] s_tdata = '0;     // eta, phi, particle_id, tally_index
	logic [1:0]  s_tuser = '0;     // cmd
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;          // b_count, light_count, electron_count,
	                               // muon_count, jet_has_b, jets_with_b,
	                               // tally_value, zero pad
	logic [1:0]  m_tuser;          // kind

	jet_particle_cone_matcher dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always #5 clk = ~clk;

	// predictor state
	logic signed [COORD_W-1:0] store_eta [MAX_PARTICLES];
	logic signed [COORD_W-1:0] store_phi [MAX_PARTICLES];
	logic signed [ID_W-1:0]    store_pid [MAX_PARTICLES];
	int                        stored_count = 0;
	int                        b_jets_in_event = 0;
	logic [TALLY_W-1:0]        tally_reg [NUM_TALLIES] = '{default: '0};
	int                        cone_sq = int'(CONE_RESET);

	stim_t   stim_q [$];
	result_t expected_results [$];
	bit      failed = 1'b0;
	bit      tight = 1'b0;
	int      queued = 0;

	stim_t   drv_item;
	bit      drv_busy = 1'b0;
	int      drv_wait = 0;
	int      rx_wait = 0;
	bit      rx_calm = 1'b0;
	int      results_seen = 0;
	int      cycle_count = 0;

	function automatic void bump_tally(input int k);
		if (tally_reg[k] != '1)
			tally_reg[k]++;
	endfunction

	function automatic void apply_command(input stim_t it);
		result_t r;
		int      nb, nl, ne, nm, de, dp, a;
		r.kind = KIND_JET;
		r.nb = '0;
		r.nl = '0;
		r.ne = '0;
		r.nm = '0;
		r.has_b = 1'b0;
		r.jwb = '0;
		r.tally = '0;
		case (it.cmd)
			CMD_LOAD: begin
				// drop loads into a full store
				if (stored_count < MAX_PARTICLES) begin
					store_eta[stored_count] = it.eta;
					store_phi[stored_count] = it.phi;
					store_pid[stored_count] = it.pid;
					stored_count++;
				end
				return;
			end
			CMD_MATCH: begin
				nb = 0;
				nl = 0;
				ne = 0;
				nm = 0;
				for (int i = 0; i < stored_count; i++) begin
					de = int'(it.eta) - int'(store_eta[i]);
					dp = int'(it.phi) - int'(store_phi[i]);
					if (de * de + dp * dp <= cone_sq) begin
						a = int'(store_pid[i]);
						if (a < 0)
							a = -a;
						if (a == ID_B && nb < HIT_MAX)
							nb++;
						if (a <= ID_LIGHT_MAX && nl < HIT_MAX)
							nl++;
						if (a == ID_ELECTRON && ne < HIT_MAX)
							ne++;
						if (a == ID_MUON && nm < HIT_MAX)
							nm++;
					end
				end
				if (nb > 0 && b_jets_in_event < 255)
					b_jets_in_event++;
				if (nb == 1)
					bump_tally(TALLY_ONE_B);
				if (nb == 2)
					bump_tally(TALLY_TWO_B);
				if (nl == 1)
					bump_tally(TALLY_ONE_LT);
				if (nb > 1)
					bump_tally(TALLY_MULTI_B);
				if (ne > 0 && nb == 0 && nl == 0)
					bump_tally(TALLY_ELEC_ONL);
				if (nm > 0 && nb == 0 && nl == 0)
					bump_tally(TALLY_MUON_ONL);
				r.kind = KIND_JET;
				r.nb = HIT_W'(nb);
				r.nl = HIT_W'(nl);
				r.ne = HIT_W'(ne);
				r.nm = HIT_W'(nm);
				r.has_b = (nb > 0);
			end
			CMD_CLOSE: begin
				if (b_jets_in_event < NUM_EV_TALLIES)
					bump_tally(TALLY_EV0 + b_jets_in_event);
				r.kind = KIND_CLOSE;
				r.jwb = EJB_W'(b_jets_in_event);
				b_jets_in_event = 0;
				stored_count = 0;
			end
			default: begin
				r.kind = KIND_TALLY;
				r.tally = (it.tidx < NUM_TALLIES) ? tally_reg[it.tidx] : '0;
			end
		endcase
		expected_results = {expected_results, r};
	endfunction

	function automatic void check_field(input string name, input longint unsigned want,
			input longint unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			failed = 1'b1;
		end
	endfunction

	function automatic int clamp_coord(input int v);
		if (v > 8191)
			return 8191;
		if (v < -8192)
			return -8192;
		return v;
	endfunction

	function automatic int rand_coord();
		return int'($urandom_range(0, 16383)) - 8192;
	endfunction

	function automatic int pick_id();
		int sgn;
		sgn = $urandom_range(0, 1) ? -1 : 1;
		case ($urandom_range(0, 9))
			0, 1: return sgn * 5;
			2, 3: return int'($urandom_range(0, 8)) - 4;
			4: return sgn * 11;
			5: return sgn * 13;
			6: return int'($urandom_range(0, 24'hFFFFFF)) - 8388608;
			7: return sgn * (($urandom_range(0, 1) ? 6 : 12) + 2 * $urandom_range(0, 1));
			default: return int'($urandom_range(0, 40)) - 20;
		endcase
	endfunction

	// unused fields of a command carry random bits
	task automatic push_cmd(input cmd_t c, input int e, input int p, input int id,
			input int t);
		stim_t it;
		it.cmd = c;
		it.eta = COORD_W'((c == CMD_LOAD || c == CMD_MATCH) ? e : rand_coord());
		it.phi = COORD_W'((c == CMD_LOAD || c == CMD_MATCH) ? p : rand_coord());
		it.pid = ID_W'((c == CMD_LOAD) ? id : int'($urandom()));
		it.tidx = TIDX_W'((c == CMD_READ) ? t : int'($urandom_range(0, 15)));
		it.gap = tight ? 0 : $urandom_range(0, 10);
		it.drain = ($urandom_range(0, 59) == 0);
		stim_q = {stim_q, it};
		queued++;
	endtask

	task automatic queue_event(input int span);
		int pe [$];
		int pp [$];
		int np, nj, ce, cp, e, p, k;
		tight = ($urandom_range(0, 3) == 0);
		np = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 70) : $urandom_range(0, 8);
		if ($urandom_range(0, 7) == 0) begin
			ce = rand_coord();
			cp = rand_coord();
		end else begin
			ce = int'($urandom_range(0, 6000)) - 3000;
			cp = int'($urandom_range(0, 6000)) - 3000;
		end
		for (int i = 0; i < np; i++) begin
			e = clamp_coord(ce + int'($urandom_range(0, 2 * span)) - span);
			p = clamp_coord(cp + int'($urandom_range(0, 2 * span)) - span);
			pe = {pe, e};
			pp = {pp, p};
			push_cmd(CMD_LOAD, e, p, pick_id(), 0);
		end
		nj = $urandom_range(0, 6);
		for (int j = 0; j < nj; j++) begin
			if (pe.size() > 0 && $urandom_range(0, 3) != 0) begin
				k = $urandom_range(0, pe.size() - 1);
				if ($urandom_range(0, 4) == 0) begin
					e = pe[k];
					p = pp[k];
				end else begin
					e = clamp_coord(pe[k] + int'($urandom_range(0, 2 * span)) - span);
					p = clamp_coord(pp[k] + int'($urandom_range(0, 2 * span)) - span);
				end
			end else begin
				e = rand_coord();
				p = rand_coord();
			end
			push_cmd(CMD_MATCH, e, p, 0, 0);
			if ($urandom_range(0, 5) == 0)
				push_cmd(CMD_READ, 0, 0, 0, $urandom_range(0, 15));
			if ($urandom_range(0, 19) == 0)
				push_cmd(cmd_t'($urandom_range(0, 3)), rand_coord(), rand_coord(),
					int'($urandom_range(0, 24'hFFFFFF)) - 8388608, $urandom_range(0, 15));
		end
		if ($urandom_range(0, 9) != 0)
			push_cmd(CMD_CLOSE, 0, 0, 0, 0);
	endtask

	task automatic run_events(input int n_items, input int span);
		int target;
		target = queued + n_items;
		while (queued < target)
			queue_event(span);
	endtask

	task automatic wait_idle();
		while (stim_q.size() > 0 || drv_busy || s_tvalid || expected_results.size() > 0)
			@(posedge clk);
		// a trailing load or jet may still be in flight
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_cone(input int v);
		wait_idle();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= CONE_W'(v);
		@(posedge clk);
		cfg_we <= 1'b0;
		cone_sq = v;
	endtask

	always @(posedge clk or negedge arst_n) begin : drive
		bit offer;
		bit hold;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			drv_busy = 1'b0;
		end else begin
			offer = 1'b0;
			hold = s_tvalid && !s_tready;
			if (s_tvalid && s_tready) begin
				apply_command(drv_item);
				drv_busy = 1'b0;
			end
			if (!drv_busy && stim_q.size() > 0) begin
				drv_item = stim_q.pop_front();
				drv_wait = drv_item.gap;
				drv_busy = 1'b1;
			end
			if (hold) begin
				offer = 1'b1;
			end else if (drv_busy) begin
				if (drv_wait > 0)
					drv_wait--;
				else
					offer = !(drv_item.drain && expected_results.size() > 0);
			end
			s_tvalid <= offer;
			if (offer) begin
				s_tdata <= {drv_item.tidx, drv_item.pid, drv_item.phi, drv_item.eta};
				s_tuser <= drv_item.cmd;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : collect
		result_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_wait = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					$error("result with no item waiting, kind %0d", m_tuser);
					failed = 1'b1;
				end else begin
					want = expected_results.pop_front();
					check_field("kind", want.kind, m_tuser);
					check_field("b_count", want.nb, m_tdata[6:0]);
					check_field("light_count", want.nl, m_tdata[13:7]);
					check_field("electron_count", want.ne, m_tdata[20:14]);
					check_field("muon_count", want.nm, m_tdata[27:21]);
					check_field("jet_has_b", want.has_b, m_tdata[28]);
					check_field("jets_with_b", want.jwb, m_tdata[36:29]);
					check_field("tally_value", want.tally, m_tdata[68:37]);
				end
				if (results_seen % 150 == 0)
					rx_calm = !rx_calm;
				// long hold so the block backs up into its input
				if (results_seen == 300 || results_seen == 1100)
					rx_wait = 400;
				else
					rx_wait = rx_calm ? 0 : $urandom_range(0, 10);
			end
			if (rx_wait > 0) begin
				rx_wait--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		int v;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty event, tally reads including out-of-range indexes
		push_cmd(CMD_CLOSE, 0, 0, 0, 0);
		push_cmd(CMD_READ, 0, 0, 0, TALLY_EV0);
		push_cmd(CMD_READ, 0, 0, 0, 15);
		push_cmd(CMD_READ, 0, 0, 0, 10);
		push_cmd(CMD_LOAD, 0, 0, 5, 0);
		push_cmd(CMD_LOAD, 100, 0, -5, 0);
		push_cmd(CMD_LOAD, 0, 300, 0, 0);
		push_cmd(CMD_LOAD, 0, -300, -4, 0);
		push_cmd(CMD_LOAD, 200, 200, 4, 0);
		push_cmd(CMD_LOAD, -8192, -8192, 11, 0);
		push_cmd(CMD_LOAD, 8191, 8191, -13, 0);
		push_cmd(CMD_LOAD, 0, 0, 8388607, 0);
		push_cmd(CMD_LOAD, 0, 0, -8388608, 0);
		push_cmd(CMD_MATCH, 0, 0, 0, 0);
		push_cmd(CMD_MATCH, -8192, -8192, 0, 0);
		push_cmd(CMD_MATCH, 8191, 8191, 0, 0);
		push_cmd(CMD_MATCH, 8191, -8192, 0, 0);
		push_cmd(CMD_MATCH, 100, 0, 0, 0);
		push_cmd(CMD_MATCH, 50, 0, 0, 0);
		push_cmd(CMD_MATCH, 0, 0, 0, 0);
		// four b jets: close bumps no event tally
		push_cmd(CMD_CLOSE, 0, 0, 0, 0);
		push_cmd(CMD_READ, 0, 0, 0, TALLY_MULTI_B);
		push_cmd(CMD_READ, 0, 0, 0, TALLY_ELEC_ONL);
		push_cmd(CMD_READ, 0, 0, 0, TALLY_MUON_ONL);

		run_events(300, 1000);

		// cone edge is inclusive
		set_cone(1000000);
		push_cmd(CMD_LOAD, 0, 0, 5, 0);
		push_cmd(CMD_LOAD, 0, 0, 1, 0);
		push_cmd(CMD_MATCH, 1000, 0, 0, 0);
		push_cmd(CMD_MATCH, 1001, 0, 0, 0);
		push_cmd(CMD_MATCH, -600, -800, 0, 0);
		push_cmd(CMD_MATCH, 0, 1001, 0, 0);
		push_cmd(CMD_CLOSE, 0, 0, 0, 0);
		push_cmd(CMD_READ, 0, 0, 0, TALLY_ONE_B);
		run_events(250, 1100);

		set_cone(0);
		run_events(200, 2);

		set_cone(268435456);
		run_events(200, 16383);
		// saturate the per-event b-jet count
		tight = 1'b0;
		push_cmd(CMD_LOAD, 0, 0, -5, 0);
		push_cmd(CMD_LOAD, 0, 0, 3, 0);
		for (int i = 0; i < 258; i++)
			push_cmd(CMD_MATCH, int'($urandom_range(0, 16000)) - 8000,
				int'($urandom_range(0, 16000)) - 8000, 0, 0);
		push_cmd(CMD_CLOSE, 0, 0, 0, 0);
		for (int i = TALLY_EV0; i < NUM_TALLIES; i++)
			push_cmd(CMD_READ, 0, 0, 0, i);

		set_cone($urandom_range(1, 50000));
		run_events(200, 250);
		for (int c = 0; c < 3; c++) begin
			v = $urandom_range(0, 268435456);
			set_cone(v);
			run_events(100, $rtoi($sqrt(real'(v))) + 4);
		end

		wait_idle();
		if (!failed && expected_results.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

/* filelist.f */
design/jpcm_pkg.sv
design/jpcm_ram.sv
design/jpcm_dist.sv
design/jet_particle_cone_matcher.sv
dv/tb_jet_particle_cone_matcher.sv
